### src/lc3_pkg.sv
// Shared types and constants of the LC-3 instruction executor.
package lc3_pkg;
    localparam int ADDR_BITS = 16;
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;
    localparam logic [15:0] RESET_PC = 16'h3000;
    localparam logic [2:0] FLAG_P = 3'd1;
    localparam logic [2:0] FLAG_Z = 3'd2;
    localparam logic [2:0] FLAG_N = 3'd4;
    localparam logic [3:0] OP_BR = 4'd0, OP_ADD = 4'd1, OP_LD = 4'd2, OP_ST = 4'd3,
        OP_JSR = 4'd4, OP_AND = 4'd5, OP_LDR = 4'd6, OP_STR = 4'd7, OP_RTI = 4'd8,
        OP_NOT = 4'd9, OP_LDI = 4'd10, OP_STI = 4'd11, OP_JMP = 4'd12,
        OP_RES = 4'd13, OP_LEA = 4'd14, OP_TRAP = 4'd15;
    localparam logic [7:0] SVC_GETC = 8'h20, SVC_OUT = 8'h21, SVC_IN = 8'h23,
        SVC_HALT = 8'h25;

    typedef logic [ADDR_BITS-1:0] maddr_t;

    // Request from the sequencer to the word memory.
    typedef struct packed {
        logic   en;
        logic   we;
        maddr_t addr;
        logic [15:0] wdata;
    } mem_req_t;

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        if (v == 16'd0)
            return FLAG_Z;
        else if (v[15])
            return FLAG_N;
        else
            return FLAG_P;
    endfunction
endpackage

### src/lc3_mem.sv
// Single-port synchronous word memory with a registered read.
module lc3_mem (
    input  logic              clk,
    input  lc3_pkg::mem_req_t req,
    output logic [15:0]       rdata
);
    import lc3_pkg::*;

    logic [15:0] mem [0:(1<<ADDR_BITS)-1];

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
                mem[req.addr] <= req.wdata;
            else
                rdata <= mem[req.addr];
        end
    end
endmodule

### src/lc3_instruction_executor_top.sv
// Top level of the LC-3 instruction executor: sequencer, registers and memory.
//
//  channel | signals                                  | direction
//  in      | valid, stall, command, address,          | request into the core
//          | write_data, char_in                      |
//  out     | out_valid, out_stall, read_data, char_out| result out of the core
//          | char_out_valid, trap_vector, trap_taken, |
//          | halted, fault, program_counter           |
//
// A write or read goes through MEMOP; a step goes through FETCH, then DATA for
// LD and LDR, PTR for STI or PTR and DATA for LDI, as the single memory port
// serves fetch, pointer read and data access in turn. A step on a stopped core
// or the unused command skips these; each passes DONE and IDLE before the next.
// Reset puts the PC at 0x3000, the flags at Z and clears the registers; the
// memory holds nothing defined until written. One result is held in an output
// register; a new request is taken once that register is free or being taken.
module lc3_instruction_executor_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [1:0]  command,
    input  logic [15:0] address,
    input  logic [15:0] write_data,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic [7:0]  char_out,
    output logic        char_out_valid,
    output logic [7:0]  trap_vector,
    output logic        trap_taken,
    output logic        halted,
    output logic        fault,
    output logic [15:0] program_counter
);
    import lc3_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_MEMOP = 3'd1, ST_FETCH = 3'd2,
        ST_PTR = 3'd3, ST_DATA = 3'd4, ST_DONE = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [15:0] regs_reg [0:7];
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  flags_reg, flags_next;
    logic        stop_reg, stop_next;
    logic [15:0] instr_reg, instr_next;
    logic [1:0]  cmd_reg;
    logic [7:0]  ch_reg;
    logic        ovalid_reg, ovalid_next;
    logic [15:0] rd_reg, rd_next;
    logic [7:0]  co_reg, co_next;
    logic        cov_reg, cov_next;
    logic [7:0]  tv_reg, tv_next;
    logic        tt_reg, tt_next;
    logic        flt_reg, flt_next;
    logic        rf_we;
    logic [2:0]  rf_wa;
    logic [15:0] rf_wd;
    logic        r7_we;
    logic [15:0] r7_wd;
    mem_req_t    mreq;
    logic [15:0] mrdata;
    logic        accept, out_free;

    lc3_mem u_mem (.clk(clk), .req(mreq), .rdata(mrdata));

    // Output register is free when empty or being taken this cycle.
    assign out_free = !ovalid_reg || !out_stall;
    assign stall    = !(state_reg == ST_IDLE && out_free);
    assign accept   = valid && !stall;

    logic [3:0]  op;
    logic [2:0]  dr, sr1;
    logic [15:0] off9, off6, off11, src2, base, pc1;
    always_comb
    begin
        op    = mrdata[15:12];
        dr    = mrdata[11:9];
        sr1   = mrdata[8:6];
        off9  = {{7{mrdata[8]}}, mrdata[8:0]};
        off6  = {{10{mrdata[5]}}, mrdata[5:0]};
        off11 = {{5{mrdata[10]}}, mrdata[10:0]};
        src2  = mrdata[5] ? {{11{mrdata[4]}}, mrdata[4:0]} : regs_reg[mrdata[2:0]];
        base  = regs_reg[sr1];
        pc1   = pc_reg + 16'd1;
    end

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        flags_next  = flags_reg;
        stop_next   = stop_reg;
        instr_next  = instr_reg;
        ovalid_next = ovalid_reg && out_stall;
        rd_next = rd_reg; co_next = co_reg; cov_next = cov_reg;
        tv_next = tv_reg; tt_next = tt_reg; flt_next = flt_reg;
        rf_we = 1'b0; rf_wa = dr; rf_wd = 16'd0;
        r7_we = 1'b0; r7_wd = 16'd0;
        mreq = '{en: 1'b0, we: 1'b0, addr: '0, wdata: 16'd0};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_next = 16'd0; co_next = 8'd0; cov_next = 1'b0;
                    tv_next = 8'd0; tt_next = 1'b0; flt_next = 1'b0;
                    if (command == CMD_WRITE || command == CMD_READ)
                    begin
                        mreq = '{en: 1'b1, we: command == CMD_WRITE,
                                 addr: address[ADDR_BITS-1:0], wdata: write_data};
                        state_next = ST_MEMOP;
                    end
                    else if (command == CMD_STEP && !stop_reg)
                    begin
                        mreq.en   = 1'b1;
                        mreq.addr = pc_reg[ADDR_BITS-1:0];
                        state_next = ST_FETCH;
                    end
                    else
                        state_next = ST_DONE;
                end
            end
            ST_MEMOP:
            begin
                if (cmd_reg == CMD_READ)
                    rd_next = mrdata;
                state_next = ST_DONE;
            end
            ST_FETCH:
            begin
                instr_next = mrdata;
                pc_next    = pc1;
                state_next = ST_DONE;
                case (op)
                    OP_BR:
                        if ((dr & flags_reg) != 3'd0)
                            pc_next = pc1 + off9;
                    OP_ADD:
                    begin
                        rf_we = 1'b1; rf_wd = base + src2;
                    end
                    OP_AND:
                    begin
                        rf_we = 1'b1; rf_wd = base & src2;
                    end
                    OP_NOT:
                    begin
                        rf_we = 1'b1; rf_wd = ~base;
                    end
                    OP_LEA:
                    begin
                        rf_we = 1'b1; rf_wd = pc1 + off9;
                    end
                    OP_LD, OP_LDI:
                    begin
                        mreq.en = 1'b1; mreq.addr = maddr_t'(pc1 + off9);
                        state_next = (op == OP_LD) ? ST_DATA : ST_PTR;
                    end
                    OP_ST:
                    begin
                        mreq = '{en: 1'b1, we: 1'b1, addr: maddr_t'(pc1 + off9),
                                 wdata: regs_reg[dr]};
                    end
                    OP_STI:
                    begin
                        mreq.en = 1'b1; mreq.addr = maddr_t'(pc1 + off9);
                        state_next = ST_PTR;
                    end
                    OP_LDR:
                    begin
                        mreq.en = 1'b1; mreq.addr = maddr_t'(base + off6);
                        state_next = ST_DATA;
                    end
                    OP_STR:
                    begin
                        mreq = '{en: 1'b1, we: 1'b1, addr: maddr_t'(base + off6),
                                 wdata: regs_reg[dr]};
                    end
                    OP_JSR:
                    begin
                        r7_we = 1'b1; r7_wd = pc1;
                        pc_next = mrdata[11] ? pc1 + off11 : base;
                    end
                    OP_JMP:
                        pc_next = base;
                    OP_TRAP:
                    begin
                        r7_we = 1'b1; r7_wd = pc1;
                        tv_next = mrdata[7:0]; tt_next = 1'b1;
                        case (mrdata[7:0])
                            SVC_GETC:
                            begin
                                rf_we = 1'b1; rf_wa = 3'd0; rf_wd = {8'd0, ch_reg};
                            end
                            SVC_OUT:
                            begin
                                co_next = regs_reg[0][7:0]; cov_next = 1'b1;
                            end
                            SVC_IN:
                            begin
                                rf_we = 1'b1; rf_wa = 3'd0; rf_wd = {8'd0, ch_reg};
                                co_next = ch_reg; cov_next = 1'b1;
                            end
                            SVC_HALT:
                                stop_next = 1'b1;
                            default: ;
                        endcase
                    end
                    default:
                    begin
                        flt_next = 1'b1; stop_next = 1'b1;
                    end
                endcase
                if (rf_we)
                    flags_next = flags_of(rf_wd);
            end
            ST_PTR:
            begin
                // Pointer word fetched; now the indirect access.
                if (instr_reg[15:12] == OP_STI)
                begin
                    mreq = '{en: 1'b1, we: 1'b1, addr: maddr_t'(mrdata),
                             wdata: regs_reg[instr_reg[11:9]]};
                    state_next = ST_DONE;
                end
                else
                begin
                    mreq.en = 1'b1; mreq.addr = maddr_t'(mrdata);
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                rf_we = 1'b1; rf_wa = instr_reg[11:9]; rf_wd = mrdata;
                flags_next = flags_of(mrdata);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                ovalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pc_reg     <= RESET_PC;
            flags_reg  <= FLAG_Z;
            stop_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                regs_reg[i] <= 16'd0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            flags_reg  <= flags_next;
            stop_reg   <= stop_next;
            ovalid_reg <= ovalid_next;
            // R7 link is written first so a later destination write wins.
            if (r7_we)
                regs_reg[7] <= r7_wd;
            if (rf_we)
                regs_reg[rf_wa] <= rf_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            ch_reg  <= char_in;
        end
        instr_reg <= instr_next;
        rd_reg <= rd_next; co_reg <= co_next; cov_reg <= cov_next;
        tv_reg <= tv_next; tt_reg <= tt_next; flt_reg <= flt_next;
    end

    assign out_valid       = ovalid_reg;
    assign read_data       = rd_reg;
    assign char_out        = co_reg;
    assign char_out_valid  = cov_reg;
    assign trap_vector     = tv_reg;
    assign trap_taken      = tt_reg;
    assign halted          = stop_reg;
    assign fault           = flt_reg;
    assign program_counter = pc_reg;

    // A fault always leaves the core stopped.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (!fault || halted))
        else $error("fault reported without halt");
    // Once stopped, the core stays stopped.
    assert property (@(posedge clk) disable iff (!rst_n) halted |=> halted)
        else $error("halt cleared");
    // No request is taken while work is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> stall)
        else $error("request taken while busy");
endmodule

### test/tb_lc3_instruction_executor_top.sv
// Self-checking testbench for the LC-3 instruction executor top level.
`timescale 1ns / 1ps

module tb_lc3_instruction_executor_top;
    import lc3_pkg::*;

    // The command value that the core ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One result of the core, with every field at its port width.
    typedef struct {
        logic [15:0] read_data;
        logic [7:0]  char_out;
        logic        char_out_valid;
        logic [7:0]  trap_vector;
        logic        trap_taken;
        logic        halted;
        logic        fault;
        logic [15:0] program_counter;
    } core_result_t;

    // A row of the directed table. Where typed is set, the read word and the PC
    // given here stand in for the predicted ones.
    typedef struct {
        logic [1:0]  command;
        logic [15:0] address;
        logic [15:0] write_data;
        logic [7:0]  char_in;
        logic        typed;
        logic [15:0] read_data;
        logic [15:0] program_counter;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        stall;
    logic [1:0]  command;
    logic [15:0] address;
    logic [15:0] write_data;
    logic [7:0]  char_in;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] read_data;
    logic [7:0]  char_out;
    logic        char_out_valid;
    logic [7:0]  trap_vector;
    logic        trap_taken;
    logic        halted;
    logic        fault;
    logic [15:0] program_counter;

    // The predicted architectural state of the core.
    logic [15:0] shadow_mem [0:65535];
    bit          shadow_written [0:65535];
    logic [15:0] written_addrs[$];
    logic [15:0] shadow_regs [0:7];
    logic [15:0] shadow_pc;
    logic [2:0]  shadow_flags;
    logic        shadow_stopped;

    core_result_t pending_results[$];
    int           mismatches;
    logic         request_taken;
    int           out_hold;

    lc3_instruction_executor_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .valid(valid),
        .stall(stall),
        .command(command),
        .address(address),
        .write_data(write_data),
        .char_in(char_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .char_out(char_out),
        .char_out_valid(char_out_valid),
        .trap_vector(trap_vector),
        .trap_taken(trap_taken),
        .halted(halted),
        .fault(fault),
        .program_counter(program_counter)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Most gaps are short or absent; now and then a long one is drawn, so that
    // idle cycles land on every phase of a multi-cycle step.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Request acceptance is registered at the rising edge, so the driver can
    // read it at the following falling edge without any race.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            request_taken <= 1'b0;
        else
            request_taken <= valid && !stall;
    end

    // The result side holds stall high or low for runs of random length.
    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_hold <= out_hold - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            out_hold <= gap_length();
        end
    end

    function automatic logic [2:0] flags_for(input logic [15:0] value);
        if (value == 16'd0)
            return FLAG_Z;
        else if (value[15])
            return FLAG_N;
        else
            return FLAG_P;
    endfunction

    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        shadow_regs[index] = value;
        shadow_flags = flags_for(value);
    endtask

    task automatic store_word(input logic [15:0] addr, input logic [15:0] value);
        shadow_mem[addr] = value;
        if (!shadow_written[addr])
        begin
            shadow_written[addr] = 1'b1;
            written_addrs.push_back(addr);
        end
    endtask

    // Works out the result of one request and moves the shadow state along.
    task automatic execute_request(input logic [1:0] cmd, input logic [15:0] addr,
                                   input logic [15:0] wdata, input logic [7:0] ch,
                                   output core_result_t res);
        logic [15:0] instr;
        logic [15:0] off9;
        logic [15:0] off6;
        logic [15:0] operand;
        logic [15:0] target;
        logic [3:0]  opcode;
        logic [2:0]  dr;
        logic [2:0]  sr1;
        res = '{default: '0};
        if (cmd == CMD_WRITE)
        begin
            store_word(addr, wdata);
        end
        else if (cmd == CMD_READ)
        begin
            res.read_data = shadow_mem[addr];
        end
        else if (cmd == CMD_STEP && !shadow_stopped)
        begin
            instr = shadow_mem[shadow_pc];
            opcode = instr[15:12];
            dr = instr[11:9];
            sr1 = instr[8:6];
            off9 = {{7{instr[8]}}, instr[8:0]};
            off6 = {{10{instr[5]}}, instr[5:0]};
            shadow_pc = shadow_pc + 16'd1;
            operand = instr[5] ? {{11{instr[4]}}, instr[4:0]} : shadow_regs[instr[2:0]];
            case (opcode)
                OP_BR:
                    if ((dr & shadow_flags) != 3'd0)
                        shadow_pc = shadow_pc + off9;
                OP_ADD:
                    write_register(dr, shadow_regs[sr1] + operand);
                OP_AND:
                    write_register(dr, shadow_regs[sr1] & operand);
                OP_NOT:
                    write_register(dr, ~shadow_regs[sr1]);
                OP_LD:
                    write_register(dr, shadow_mem[shadow_pc + off9]);
                OP_LDI:
                    write_register(dr, shadow_mem[shadow_mem[shadow_pc + off9]]);
                OP_LDR:
                    write_register(dr, shadow_mem[shadow_regs[sr1] + off6]);
                OP_LEA:
                    write_register(dr, shadow_pc + off9);
                OP_ST:
                    store_word(shadow_pc + off9, shadow_regs[dr]);
                OP_STI:
                    store_word(shadow_mem[shadow_pc + off9], shadow_regs[dr]);
                OP_STR:
                    store_word(shadow_regs[sr1] + off6, shadow_regs[dr]);
                OP_JSR:
                begin
                    // The base register is read before R7 takes the return address.
                    if (instr[11])
                        target = shadow_pc + {{5{instr[10]}}, instr[10:0]};
                    else
                        target = shadow_regs[sr1];
                    shadow_regs[7] = shadow_pc;
                    shadow_pc = target;
                end
                OP_JMP:
                    shadow_pc = shadow_regs[sr1];
                OP_TRAP:
                begin
                    shadow_regs[7] = shadow_pc;
                    res.trap_vector = instr[7:0];
                    res.trap_taken = 1'b1;
                    case (instr[7:0])
                        SVC_GETC:
                            write_register(3'd0, {8'd0, ch});
                        SVC_OUT:
                        begin
                            res.char_out = shadow_regs[0][7:0];
                            res.char_out_valid = 1'b1;
                        end
                        SVC_IN:
                        begin
                            write_register(3'd0, {8'd0, ch});
                            res.char_out = ch;
                            res.char_out_valid = 1'b1;
                        end
                        SVC_HALT:
                            shadow_stopped = 1'b1;
                        default:
                            ;
                    endcase
                end
                default:
                begin
                    // Return from interrupt and the reserved opcode both stop the core.
                    res.fault = 1'b1;
                    shadow_stopped = 1'b1;
                end
            endcase
        end
        res.halted = shadow_stopped;
        res.program_counter = shadow_pc;
    endtask

    // Presents one request, predicts its result and waits until it is taken.
    task automatic send_request(input logic [1:0] cmd, input logic [15:0] addr,
                                input logic [15:0] wdata, input logic [7:0] ch,
                                input logic typed, input logic [15:0] typed_read,
                                input logic [15:0] typed_pc);
        core_result_t res;
        int gap;
        gap = gap_length();
        repeat (gap)
        begin
            @(negedge clk);
            valid <= 1'b0;
        end
        @(negedge clk);
        valid <= 1'b1;
        command <= cmd;
        address <= addr;
        write_data <= wdata;
        char_in <= ch;
        execute_request(cmd, addr, wdata, ch, res);
        if (typed)
        begin
            res.read_data = typed_read;
            res.program_counter = typed_pc;
        end
        pending_results.push_back(res);
        do
            @(negedge clk);
        while (!request_taken);
        valid <= 1'b0;
    endtask

    task automatic send(input logic [1:0] cmd, input logic [15:0] addr,
                        input logic [15:0] wdata, input logic [7:0] ch);
        send_request(cmd, addr, wdata, ch, 1'b0, 16'd0, 16'd0);
    endtask

    // Writes random contents into a word that is about to be read, unless it
    // already holds something.
    task automatic fill_if_blank(input logic [15:0] addr);
        if (!shadow_written[addr])
            send(CMD_WRITE, addr, 16'($urandom), 8'($urandom));
    endtask

    function automatic logic stops_core(input logic [15:0] instr);
        return instr[15:12] == OP_RTI || instr[15:12] == OP_RES ||
               (instr[15:12] == OP_TRAP && instr[7:0] == SVC_HALT);
    endfunction

    // Picks an instruction that keeps the core running. Traps favour the
    // vectors 0x20 to 0x24.
    function automatic logic [15:0] running_instruction();
        logic [15:0] instr;
        do
        begin
            instr = 16'($urandom);
            if (instr[15:12] == OP_TRAP && $urandom_range(0, 3) != 0)
                instr[7:0] = SVC_GETC + 8'($urandom_range(0, 4));
        end
        while (stops_core(instr));
        return instr;
    endfunction

    // One instruction step: the word at the PC and every word that the step
    // will read are written first, so that no read touches blank memory.
    task automatic random_step();
        logic [15:0] instr;
        logic [15:0] pointer_addr;
        if (shadow_written[shadow_pc] && !stops_core(shadow_mem[shadow_pc]) &&
            $urandom_range(0, 3) == 0)
            instr = shadow_mem[shadow_pc];
        else
        begin
            instr = running_instruction();
            send(CMD_WRITE, shadow_pc, instr, 8'($urandom));
        end
        pointer_addr = shadow_pc + 16'd1 + {{7{instr[8]}}, instr[8:0]};
        case (instr[15:12])
            OP_LD, OP_STI:
                fill_if_blank(pointer_addr);
            OP_LDI:
            begin
                fill_if_blank(pointer_addr);
                fill_if_blank(shadow_mem[pointer_addr]);
            end
            OP_LDR:
                fill_if_blank(shadow_regs[instr[8:6]] + {{10{instr[5]}}, instr[5:0]});
            default:
                ;
        endcase
        send(CMD_STEP, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Results are compared at the rising edge, against the oldest prediction.
    always @(posedge clk)
    begin
        core_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request waiting for it");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data, read_data);
                    mismatches++;
                end
                if (char_out !== want.char_out)
                begin
                    $error("char_out: expected %h, got %h", want.char_out, char_out);
                    mismatches++;
                end
                if (char_out_valid !== want.char_out_valid)
                begin
                    $error("char_out_valid: expected %b, got %b",
                           want.char_out_valid, char_out_valid);
                    mismatches++;
                end
                if (trap_vector !== want.trap_vector)
                begin
                    $error("trap_vector: expected %h, got %h", want.trap_vector, trap_vector);
                    mismatches++;
                end
                if (trap_taken !== want.trap_taken)
                begin
                    $error("trap_taken: expected %b, got %b", want.trap_taken, trap_taken);
                    mismatches++;
                end
                if (halted !== want.halted)
                begin
                    $error("halted: expected %b, got %b", want.halted, halted);
                    mismatches++;
                end
                if (fault !== want.fault)
                begin
                    $error("fault: expected %b, got %b", want.fault, fault);
                    mismatches++;
                end
                if (program_counter !== want.program_counter)
                begin
                    $error("program_counter: expected %h, got %h",
                           want.program_counter, program_counter);
                    mismatches++;
                end
            end
        end
    end

    // The directed table builds a short program at 0x3000 and also touches
    // the lowest and highest addresses, the GETC, OUT and IN trap services and
    // the unused command. The JSRR through R7 row jumps to the address that the
    // trap at vector 0x22 just left in R7.
    directed_row_t directed_rows [] = '{
        '{CMD_WRITE,  16'h3000, 16'h1270, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_READ,   16'h3000, 16'h0000, 8'h00, 1'b1, 16'h1270, 16'h3000},
        '{CMD_STEP,   16'h0000, 16'h0000, 8'h00, 1'b1, 16'h0000, 16'h3001},
        '{CMD_WRITE,  16'h3001, 16'h947F, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_STEP,   16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'h0000, 16'h3002},
        '{CMD_WRITE,  16'h3002, 16'h5642, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_STEP,   16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_WRITE,  16'h0000, 16'hFFFF, 8'hFF, 1'b0, 16'h0000, 16'h0000},
        '{CMD_WRITE,  16'hFFFF, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_READ,   16'hFFFF, 16'h0000, 8'h00, 1'b1, 16'h0000, 16'h3003},
        '{CMD_READ,   16'h0000, 16'h0000, 8'h00, 1'b1, 16'hFFFF, 16'h3003},
        '{CMD_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'h0000, 16'h3003},
        '{CMD_WRITE,  16'h3003, 16'hF021, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_STEP,   16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_WRITE,  16'h3004, 16'hF023, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_STEP,   16'h0000, 16'h0000, 8'hFF, 1'b0, 16'h0000, 16'h0000},
        '{CMD_WRITE,  16'h3005, 16'hF020, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_STEP,   16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_WRITE,  16'h3006, 16'hE900, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_STEP,   16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_WRITE,  16'h3007, 16'hF022, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_STEP,   16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_WRITE,  16'h3008, 16'h41C0, 8'h00, 1'b0, 16'h0000, 16'h0000},
        '{CMD_STEP,   16'h0000, 16'h0000, 8'h00, 1'b1, 16'h0000, 16'h3008}
    };

    // A generous ceiling on the whole run; a hang ends here as a failure.
    initial
    begin
        #10ms;
        $display("lc3_instruction_executor_top regression: fail");
        $finish;
    end

    initial
    begin
        logic [15:0] stop_word;
        int pick;
        int wait_cycles;
        valid = 1'b0;
        command = CMD_WRITE;
        address = 16'd0;
        write_data = 16'd0;
        char_in = 8'd0;
        out_stall = 1'b0;
        out_hold = 0;
        mismatches = 0;
        rst_n = 1'b0;
        for (int i = 0; i < 8; i++)
            shadow_regs[i] = 16'd0;
        shadow_pc = RESET_PC;
        shadow_flags = FLAG_Z;
        shadow_stopped = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].command, directed_rows[i].address,
                         directed_rows[i].write_data, directed_rows[i].char_in,
                         directed_rows[i].typed, directed_rows[i].read_data,
                         directed_rows[i].program_counter);

        // The random part is mostly instruction steps, with memory writes,
        // reads of words already written and the unused command mixed in.
        repeat (280)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                random_step();
            else if (pick < 80)
                send(CMD_WRITE, 16'($urandom), 16'($urandom), 8'($urandom));
            else if (pick < 95)
                send(CMD_READ, written_addrs[$urandom_range(0, written_addrs.size() - 1)],
                     16'($urandom), 8'($urandom));
            else
                send(CMD_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom));
        end

        // The core can only be stopped once, so the stop comes last: HALT, a
        // return from interrupt or the reserved opcode, then steps and memory
        // traffic against the stopped core.
        pick = $urandom_range(0, 2);
        if (pick == 0)
            stop_word = {OP_TRAP, 4'($urandom), SVC_HALT};
        else if (pick == 1)
            stop_word = {OP_RTI, 12'($urandom)};
        else
            stop_word = {OP_RES, 12'($urandom)};
        send(CMD_WRITE, shadow_pc, stop_word, 8'($urandom));
        send(CMD_STEP, 16'($urandom), 16'($urandom), 8'($urandom));
        repeat (3)
            send(CMD_STEP, 16'($urandom), 16'($urandom), 8'($urandom));
        send(CMD_WRITE, 16'h4000, 16'hA5A5, 8'($urandom));
        send(CMD_READ, 16'h4000, 16'($urandom), 8'($urandom));
        send(CMD_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom));

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (20) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("lc3_instruction_executor_top regression: pass");
        else
            $display("lc3_instruction_executor_top regression: fail");
        $finish;
    end
endmodule
